>>> hw/rtl/wtw_pkg.sv
// Shared types, mode and action codes for the wipe transition window block.
`timescale 1ns / 1ps
`default_nettype none

package wtw_pkg;

  localparam int COORD_BITS_DEF     = 11;
  localparam int STEP_BITS_DEF      = 6;
  localparam int DIV_BITS_PER_STAGE = 4;

  localparam logic [4:0] MODE_NONE       = 5'd0;
  localparam logic [4:0] MODE_INSTANT    = 5'd1;
  localparam logic [4:0] MODE_SNAP_ON    = 5'd2;
  localparam logic [4:0] MODE_SNAP_OFF   = 5'd3;
  localparam logic [4:0] MODE_RIGHT      = 5'd4;
  localparam logic [4:0] MODE_LEFT       = 5'd5;
  localparam logic [4:0] MODE_DOWN       = 5'd6;
  localparam logic [4:0] MODE_UP         = 5'd7;
  localparam logic [4:0] MODE_DIAG_TLBR  = 5'd8;
  localparam logic [4:0] MODE_DIAG_TRBL  = 5'd9;
  localparam logic [4:0] MODE_DIAG_BLTR  = 5'd10;
  localparam logic [4:0] MODE_DIAG_BRTL  = 5'd11;
  localparam logic [4:0] MODE_EXP_RIGHT  = 5'd12;
  localparam logic [4:0] MODE_EXP_LEFT   = 5'd13;
  localparam logic [4:0] MODE_EXP_UP     = 5'd14;
  localparam logic [4:0] MODE_EXP_DOWN   = 5'd15;
  localparam logic [4:0] MODE_CORNER_TL  = 5'd16;
  localparam logic [4:0] MODE_CORNER_TR  = 5'd17;
  localparam logic [4:0] MODE_CORNER_BL  = 5'd18;
  localparam logic [4:0] MODE_CORNER_BR  = 5'd19;
  localparam logic [4:0] MODE_IRIS_H     = 5'd20;
  localparam logic [4:0] MODE_IRIS_V     = 5'd21;
  localparam logic [4:0] MODE_IRIS_BOX   = 5'd22;
  localparam logic [4:0] MODE_SPECIAL_LO = 5'd23;
  localparam logic [4:0] MODE_SPECIAL_HI = 5'd25;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_COPY  = 2'd1;
  localparam logic [1:0] ACT_SWAP  = 2'd2;
  localparam logic [1:0] ACT_DIRTY = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [4:0] mode;
    logic       hide;
    logic       empty;
  } ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/wtw_front.sv
// Input stage: step clamp, edge lengths, snap test and the two scaling products.
`timescale 1ns / 1ps
`default_nettype none

module wtw_front #(
  parameter int COORD_BITS = 11,
  parameter int STEP_BITS  = 6
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  input  wire  [4:0]            mode_i,
  input  wire  [STEP_BITS-1:0]  step_now_i,
  input  wire  [STEP_BITS-1:0]  step_total_i,
  input  wire                   not_last_i,
  input  wire  [COORD_BITS-1:0] area_left_i,
  input  wire  [COORD_BITS-1:0] area_top_i,
  input  wire  [COORD_BITS-1:0] area_right_i,
  input  wire  [COORD_BITS-1:0] area_bottom_i,
  output wtw_pkg::ctrl_t        ctrl_o,
  output logic [COORD_BITS-1:0] left_o,
  output logic [COORD_BITS-1:0] top_o,
  output logic [COORD_BITS-1:0] right_o,
  output logic [COORD_BITS-1:0] bottom_o,
  output logic [STEP_BITS-1:0]  den_o,
  output logic [COORD_BITS+STEP_BITS-1:0] prod_w_o,
  output logic [COORD_BITS+STEP_BITS-1:0] prod_h_o
);
  import wtw_pkg::*;

  localparam int PW = COORD_BITS + STEP_BITS;

  logic [STEP_BITS-1:0]  tot, stp, rem, num;
  logic [COORD_BITS-1:0] len_w, len_h, w, h;
  logic                  iris;
  ctrl_t                 ctrl_d, ctrl_q;
  logic [PW-1:0]         prod_w_d, prod_h_d, prod_w_q, prod_h_q;
  logic [COORD_BITS-1:0] left_q, top_q, right_q, bottom_q;
  logic [STEP_BITS-1:0]  den_q;

  always_comb begin
    tot  = (step_total_i == '0) ? {{(STEP_BITS-1){1'b0}}, 1'b1} : step_total_i;
    stp  = (step_now_i > tot) ? tot : step_now_i;
    rem  = tot - stp;
    w    = area_right_i - area_left_i;
    h    = area_bottom_i - area_top_i;
    iris = (mode_i inside {[MODE_IRIS_H:MODE_IRIS_BOX]});
    // Irises scale half the edge by the remaining steps.
    len_w = iris ? (w >> 1) : w;
    len_h = iris ? (h >> 1) : h;
    num   = iris ? rem : stp;
    prod_w_d = {{STEP_BITS{1'b0}}, len_w} * {{COORD_BITS{1'b0}}, num};
    prod_h_d = {{STEP_BITS{1'b0}}, len_h} * {{COORD_BITS{1'b0}}, num};
    ctrl_d.valid = start_i;
    ctrl_d.mode  = mode_i;
    ctrl_d.hide  = (stp != (tot >> 1)) && not_last_i;
    ctrl_d.empty = (area_right_i <= area_left_i) || (area_bottom_i <= area_top_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_w_q <= prod_w_d;
    prod_h_q <= prod_h_d;
    den_q    <= tot;
    left_q   <= area_left_i;
    top_q    <= area_top_i;
    right_q  <= area_right_i;
    bottom_q <= area_bottom_i;
  end

  assign ctrl_o   = ctrl_q;
  assign prod_w_o = prod_w_q;
  assign prod_h_o = prod_h_q;
  assign den_o    = den_q;
  assign left_o   = left_q;
  assign top_o    = top_q;
  assign right_o  = right_q;
  assign bottom_o = bottom_q;

endmodule

`default_nettype wire

>>> hw/rtl/wtw_div_stage.sv
// One stage of the restoring divider: quotient bits HI_BIT down to LO_BIT for both lanes.
`timescale 1ns / 1ps
`default_nettype none

module wtw_div_stage #(
  parameter int COORD_BITS = 11,
  parameter int STEP_BITS  = 6,
  parameter int HI_BIT     = 10,
  parameter int LO_BIT     = 7
) (
  input  wire                   clk_i,
  input  wire  [STEP_BITS-1:0]  den_i,
  input  wire  [COORD_BITS+STEP_BITS-1:0] pw_i,
  input  wire  [COORD_BITS+STEP_BITS-1:0] ph_i,
  input  wire  [STEP_BITS-1:0]  rw_i,
  input  wire  [STEP_BITS-1:0]  rh_i,
  input  wire  [COORD_BITS-1:0] qw_i,
  input  wire  [COORD_BITS-1:0] qh_i,
  output logic [COORD_BITS+STEP_BITS-1:0] pw_o,
  output logic [COORD_BITS+STEP_BITS-1:0] ph_o,
  output logic [STEP_BITS-1:0]  rw_o,
  output logic [STEP_BITS-1:0]  rh_o,
  output logic [COORD_BITS-1:0] qw_o,
  output logic [COORD_BITS-1:0] qh_o
);

  logic [STEP_BITS-1:0]  rw_d, rh_d;
  logic [COORD_BITS-1:0] qw_d, qh_d;

  // The partial remainder stays below the divisor, so it fits the step width.
  always_comb begin
    logic [STEP_BITS:0] tw, th;
    rw_d = rw_i;
    rh_d = rh_i;
    qw_d = qw_i;
    qh_d = qh_i;
    for (int j = HI_BIT; j >= LO_BIT; j--) begin
      tw = {rw_d, pw_i[j]};
      th = {rh_d, ph_i[j]};
      if (tw >= {1'b0, den_i}) begin
        tw      = tw - {1'b0, den_i};
        qw_d[j] = 1'b1;
      end
      if (th >= {1'b0, den_i}) begin
        th      = th - {1'b0, den_i};
        qh_d[j] = 1'b1;
      end
      rw_d = tw[STEP_BITS-1:0];
      rh_d = th[STEP_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    pw_o <= pw_i;
    ph_o <= ph_i;
    rw_o <= rw_d;
    rh_o <= rh_d;
    qw_o <= qw_d;
    qh_o <= qh_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/wtw_back.sv
// Output stage: window edges, destination corner and action code from the quotients.
`timescale 1ns / 1ps
`default_nettype none

module wtw_back #(
  parameter int COORD_BITS = 11
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wtw_pkg::ctrl_t        ctrl_i,
  input  wire  [COORD_BITS-1:0] left_i,
  input  wire  [COORD_BITS-1:0] top_i,
  input  wire  [COORD_BITS-1:0] right_i,
  input  wire  [COORD_BITS-1:0] bottom_i,
  input  wire  [COORD_BITS-1:0] sw_i,
  input  wire  [COORD_BITS-1:0] sh_i,
  output logic                  done_o,
  output logic [COORD_BITS-1:0] win_left_o,
  output logic [COORD_BITS-1:0] win_top_o,
  output logic [COORD_BITS-1:0] win_right_o,
  output logic [COORD_BITS-1:0] win_bottom_o,
  output logic [COORD_BITS-1:0] dest_left_o,
  output logic [COORD_BITS-1:0] dest_top_o,
  output logic [1:0]            action_o
);
  import wtw_pkg::*;

  logic [COORD_BITS-1:0] wl, wt, wr, wb, dl, dt;
  logic [1:0]            act;
  logic                  done_q;
  logic [COORD_BITS-1:0] wl_q, wt_q, wr_q, wb_q, dl_q, dt_q;
  logic [1:0]            act_q;

  always_comb begin
    wl = left_i;
    wt = top_i;
    wr = right_i;
    wb = bottom_i;
    dl = left_i;
    dt = top_i;
    case (ctrl_i.mode)
      MODE_SNAP_ON, MODE_SNAP_OFF: begin
        if (ctrl_i.hide) begin
          wl = '0;
          wt = '0;
          wr = '0;
          wb = '0;
        end
      end
      MODE_RIGHT: wl = right_i - sw_i;
      MODE_LEFT: begin
        wr = left_i + sw_i;
        dl = right_i - (wr - wl);
      end
      MODE_DOWN: begin
        wb = top_i + sh_i;
        dt = bottom_i - (wb - wt);
      end
      MODE_UP: wt = bottom_i - sh_i;
      MODE_DIAG_TLBR: begin
        wt = bottom_i - sh_i;
        wr = left_i + sw_i;
        dl = right_i - (wr - wl);
      end
      MODE_DIAG_TRBL: begin
        wt = bottom_i - sh_i;
        wl = right_i - sw_i;
      end
      MODE_DIAG_BLTR: begin
        wb = top_i + sh_i;
        wr = left_i + sw_i;
        dl = right_i - (wr - wl);
        dt = bottom_i - (wb - wt);
      end
      MODE_DIAG_BRTL: begin
        wb = top_i + sh_i;
        wl = right_i - sw_i;
        dt = bottom_i - (wb - wt);
      end
      MODE_EXP_RIGHT: wr = left_i + sw_i;
      MODE_EXP_LEFT: begin
        wl = right_i - sw_i;
        dl = wl;
      end
      MODE_EXP_UP: begin
        wt = bottom_i - sh_i;
        dt = wt;
      end
      MODE_EXP_DOWN: wb = top_i + sh_i;
      MODE_CORNER_TL: begin
        wt = bottom_i - sh_i;
        dt = wt;
        wr = left_i + sw_i;
      end
      MODE_CORNER_TR: begin
        wt = bottom_i - sh_i;
        wl = right_i - sw_i;
        dl = wl;
        dt = wt;
      end
      MODE_CORNER_BL: begin
        wb = top_i + sh_i;
        wr = left_i + sw_i;
      end
      MODE_CORNER_BR: begin
        wb = top_i + sh_i;
        wl = right_i - sw_i;
        dl = wl;
      end
      MODE_IRIS_H: begin
        wl = left_i + sw_i;
        wr = right_i - sw_i;
        dl = wl;
      end
      MODE_IRIS_V: begin
        wt = top_i + sh_i;
        wb = bottom_i - sh_i;
        dt = wt;
      end
      MODE_IRIS_BOX: begin
        wt = top_i + sh_i;
        wb = bottom_i - sh_i;
        wl = left_i + sw_i;
        wr = right_i - sw_i;
        dl = wl;
        dt = wt;
      end
      default: begin
      end
    endcase

    act = ACT_NONE;
    if (wr > wl && wb > wt) begin
      if (ctrl_i.mode inside {[MODE_SPECIAL_LO:MODE_SPECIAL_HI]}) begin
        act = ACT_SWAP;
      end else if (ctrl_i.mode >= MODE_RIGHT) begin
        act = ACT_COPY;
      end else begin
        act = ACT_DIRTY;
      end
    end

    // A degenerate bounding rectangle clears the whole result.
    if (ctrl_i.empty) begin
      wl  = '0;
      wt  = '0;
      wr  = '0;
      wb  = '0;
      dl  = '0;
      dt  = '0;
      act = ACT_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    wl_q  <= wl;
    wt_q  <= wt;
    wr_q  <= wr;
    wb_q  <= wb;
    dl_q  <= dl;
    dt_q  <= dt;
    act_q <= act;
  end

  assign done_o       = done_q;
  assign win_left_o   = wl_q;
  assign win_top_o    = wt_q;
  assign win_right_o  = wr_q;
  assign win_bottom_o = wb_q;
  assign dest_left_o  = dl_q;
  assign dest_top_o   = dt_q;
  assign action_o     = act_q;

  a_empty_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.valid && ctrl_i.empty |=>
      done_o && action_o == ACT_NONE && win_right_o == '0 && dest_left_o == '0)
    else $error("empty bounding rectangle did not clear the result");

endmodule

`default_nettype wire

>>> hw/rtl/wipe_transition_window.sv
// Top level of the wipe transition window block: front stage, divider pipeline, output stage.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one request in every cycle and busy_o is never raised. Each request gives
// exactly one result on done_o, in request order, after passing the front stage register,
// the divider stage registers and the output stage register. The restoring divider by
// step_total resolves up to four quotient bits per pipeline stage; the stages before and
// after it hold the products and the final edge selection. Results are shown for one cycle
// and must be taken then.
module wipe_transition_window #(
  parameter int COORD_BITS = wtw_pkg::COORD_BITS_DEF,
  parameter int STEP_BITS  = wtw_pkg::STEP_BITS_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  output logic                  busy_o,
  input  wire  [4:0]            mode_i,
  input  wire  [STEP_BITS-1:0]  step_now_i,
  input  wire  [STEP_BITS-1:0]  step_total_i,
  input  wire                   not_last_i,
  input  wire  [COORD_BITS-1:0] area_left_i,
  input  wire  [COORD_BITS-1:0] area_top_i,
  input  wire  [COORD_BITS-1:0] area_right_i,
  input  wire  [COORD_BITS-1:0] area_bottom_i,
  output logic                  done_o,
  output logic [COORD_BITS-1:0] win_left_o,
  output logic [COORD_BITS-1:0] win_top_o,
  output logic [COORD_BITS-1:0] win_right_o,
  output logic [COORD_BITS-1:0] win_bottom_o,
  output logic [COORD_BITS-1:0] dest_left_o,
  output logic [COORD_BITS-1:0] dest_top_o,
  output logic [1:0]            action_o
);
  import wtw_pkg::*;

  localparam int PW        = COORD_BITS + STEP_BITS;
  localparam int DivStages = (COORD_BITS + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
  localparam int Latency   = DivStages + 2;

  ctrl_t                 ctrl_a   [DivStages+1];
  logic [COORD_BITS-1:0] left_a   [DivStages+1];
  logic [COORD_BITS-1:0] top_a    [DivStages+1];
  logic [COORD_BITS-1:0] right_a  [DivStages+1];
  logic [COORD_BITS-1:0] bottom_a [DivStages+1];
  logic [STEP_BITS-1:0]  den_a    [DivStages+1];
  logic [PW-1:0]         pw_a     [DivStages+1];
  logic [PW-1:0]         ph_a     [DivStages+1];
  logic [STEP_BITS-1:0]  rw_a     [DivStages+1];
  logic [STEP_BITS-1:0]  rh_a     [DivStages+1];
  logic [COORD_BITS-1:0] qw_a     [DivStages+1];
  logic [COORD_BITS-1:0] qh_a     [DivStages+1];

  assign busy_o = 1'b0;

  wtw_front #(
    .COORD_BITS(COORD_BITS),
    .STEP_BITS (STEP_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .mode_i       (mode_i),
    .step_now_i   (step_now_i),
    .step_total_i (step_total_i),
    .not_last_i   (not_last_i),
    .area_left_i  (area_left_i),
    .area_top_i   (area_top_i),
    .area_right_i (area_right_i),
    .area_bottom_i(area_bottom_i),
    .ctrl_o       (ctrl_a[0]),
    .left_o       (left_a[0]),
    .top_o        (top_a[0]),
    .right_o      (right_a[0]),
    .bottom_o     (bottom_a[0]),
    .den_o        (den_a[0]),
    .prod_w_o     (pw_a[0]),
    .prod_h_o     (ph_a[0])
  );

  // The product is below den * 2^COORD_BITS, so its top bits seed the remainder.
  assign rw_a[0] = pw_a[0][PW-1:COORD_BITS];
  assign rh_a[0] = ph_a[0][PW-1:COORD_BITS];
  assign qw_a[0] = '0;
  assign qh_a[0] = '0;

  for (genvar s = 0; s < DivStages; s++) begin : g_div
    localparam int HiBit = COORD_BITS - 1 - s * DIV_BITS_PER_STAGE;
    localparam int LoBit = (HiBit >= DIV_BITS_PER_STAGE - 1) ?
                           HiBit - DIV_BITS_PER_STAGE + 1 : 0;

    wtw_div_stage #(
      .COORD_BITS(COORD_BITS),
      .STEP_BITS (STEP_BITS),
      .HI_BIT    (HiBit),
      .LO_BIT    (LoBit)
    ) u_stage (
      .clk_i(clk_i),
      .den_i(den_a[s]),
      .pw_i (pw_a[s]),
      .ph_i (ph_a[s]),
      .rw_i (rw_a[s]),
      .rh_i (rh_a[s]),
      .qw_i (qw_a[s]),
      .qh_i (qh_a[s]),
      .pw_o (pw_a[s+1]),
      .ph_o (ph_a[s+1]),
      .rw_o (rw_a[s+1]),
      .rh_o (rh_a[s+1]),
      .qw_o (qw_a[s+1]),
      .qh_o (qh_a[s+1])
    );

    // Side data rides alongside the divider so it meets its quotient at the end.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctrl_a[s+1] <= '0;
      end else begin
        ctrl_a[s+1] <= ctrl_a[s];
      end
    end

    always_ff @(posedge clk_i) begin
      left_a[s+1]   <= left_a[s];
      top_a[s+1]    <= top_a[s];
      right_a[s+1]  <= right_a[s];
      bottom_a[s+1] <= bottom_a[s];
      den_a[s+1]    <= den_a[s];
    end
  end

  wtw_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl_a[DivStages]),
    .left_i      (left_a[DivStages]),
    .top_i       (top_a[DivStages]),
    .right_i     (right_a[DivStages]),
    .bottom_i    (bottom_a[DivStages]),
    .sw_i        (qw_a[DivStages]),
    .sh_i        (qh_a[DivStages]),
    .done_o      (done_o),
    .win_left_o  (win_left_o),
    .win_top_o   (win_top_o),
    .win_right_o (win_right_o),
    .win_bottom_o(win_bottom_o),
    .dest_left_o (dest_left_o),
    .dest_top_o  (dest_top_o),
    .action_o    (action_o)
  );

  a_done_has_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Latency))
    else $error("result beat without a matching request");

  a_copy_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && action_o != ACT_NONE |->
      win_right_o > win_left_o && win_bottom_o > win_top_o)
    else $error("copy action on an empty window");

  a_den_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_a[0].valid |-> den_a[0] != '0)
    else $error("divider entered with a zero step count");

endmodule

`default_nettype wire
